// ===== rtl/core/svf_pkg.sv =====
package svf_pkg;

  // integer bits of the coefficient and state formats (Q8.x)
  localparam int Q_INT_BITS = 8;

  // multiplier bits consumed per cycle by the serial multiplier
  localparam int DIGIT_W = 4;

  // register index width and register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BYPASS    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_G    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A1   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIX_INPUT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIX_BAND  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIX_LOW   = 3'd6;

  // input operation codes
  localparam logic OPER_FILTER = 1'b0;
  localparam logic OPER_CLEAR  = 1'b1;

  // sequencer states of the core
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_CONV = 4'b0100,
    ST_DONE = 4'b1000
  } svf_state_t;

  // serial multiplier states
  typedef enum logic [2:0] {
    MS_IDLE  = 3'b001,
    MS_STEP  = 3'b010,
    MS_ROUND = 3'b100
  } mul_state_t;

  // product slots in the order the sequencer runs them
  typedef enum logic [2:0] {
    OP_A1S1 = 3'd0,
    OP_A2V3 = 3'd1,
    OP_GV1  = 3'd2,
    OP_M0V0 = 3'd3,
    OP_M1V1 = 3'd4,
    OP_M2V2 = 3'd5
  } op_t;

endpackage

// ===== rtl/core/svf_mul.sv =====
module svf_mul
  import svf_pkg::*;
#(
  parameter int COEF_W = 32,
  parameter int NODE_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COEF_W-1:0] coef,
  input  logic [NODE_W-1:0] node,
  output logic              done,
  output logic [NODE_W-1:0] product
);

  localparam int NSTEP = (COEF_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MW    = NSTEP * DIGIT_W;
  localparam int PW    = NODE_W + MW;
  localparam int FRAC  = COEF_W - Q_INT_BITS;
  localparam int RW    = PW + 1 - FRAC;
  localparam int CNT_W = $clog2(NSTEP + 1);
  localparam int PART_W = NODE_W + DIGIT_W;

  mul_state_t         mstate;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic [NODE_W-1:0]  mb;
  logic [PW-1:0]      prod;

  logic [COEF_W-1:0]  coef_mag;
  logic [NODE_W-1:0]  node_mag;
  logic [DIGIT_W-1:0] digit;
  logic [PART_W-1:0]  part;
  logic [PW:0]        rnd_sum;
  logic [RW-1:0]      rsh;
  logic [NODE_W-1:0]  lim;
  logic [NODE_W-1:0]  mag;

  // magnitudes, the sign is applied after rounding
  assign coef_mag = coef[COEF_W-1] ? (COEF_W'(0) - coef) : coef;
  assign node_mag = node[NODE_W-1] ? (NODE_W'(0) - node) : node;

  // one digit of the coefficient per cycle, low digit first
  assign digit = prod[DIGIT_W-1:0];
  assign part  = {{DIGIT_W{1'b0}}, prod[PW-1:MW]}
               + PART_W'(digit) * PART_W'(mb);

  // round half away from zero on the magnitude, then clamp
  assign rnd_sum = {1'b0, prod} + ((PW + 1)'(1) << (FRAC - 1));
  assign rsh     = rnd_sum[PW:FRAC];
  assign lim     = {1'b0, {(NODE_W - 1){1'b1}}} + NODE_W'(neg);
  assign mag     = (rsh > RW'(lim)) ? lim : rsh[NODE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= MS_IDLE;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (mstate)
        MS_IDLE: begin
          if (start) begin
            cnt    <= '0;
            mstate <= MS_STEP;
          end
        end
        MS_STEP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NSTEP - 1)) begin
            mstate <= MS_ROUND;
          end
        end
        MS_ROUND: begin
          done   <= 1'b1;
          mstate <= MS_IDLE;
        end
        default: mstate <= MS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mstate == MS_IDLE && start) begin
      neg  <= coef[COEF_W-1] ^ node[NODE_W-1];
      mb   <= node_mag;
      prod <= {{NODE_W{1'b0}}, MW'(coef_mag)};
    end else if (mstate == MS_STEP) begin
      prod <= {part, prod[MW-1:DIGIT_W]};
    end
    if (mstate == MS_ROUND) begin
      product <= neg ? (NODE_W'(0) - mag) : mag;
    end
  end

endmodule

// ===== rtl/core/state_variable_filter_core.sv =====
// a filter transaction runs six products in turn on the shared serial multiplier at 4 bits
//   a cycle; a bypass transaction goes straight to the output register, a clear gives no sample
// a new transaction is taken only once the last one has handed over its sample
// reset: synchronous, clears both integrators, bypass on, mix_input at unity, other
//   coefficients zero, output empty
module state_variable_filter_core
  import svf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEFF_WIDTH  = 32,
  parameter int STATE_WIDTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    operation,
  input  logic [SAMPLE_WIDTH-1:0]                 sample_in,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [SAMPLE_WIDTH-1:0]                 sample_out,
  // register port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [(COEFF_WIDTH > 32 ? 6 : 5)-1:0]   paddr,
  input  logic [(COEFF_WIDTH > 32 ? 64 : 32)-1:0] pwdata,
  output logic [(COEFF_WIDTH > 32 ? 64 : 32)-1:0] prdata,
  output logic                                    pready
);

  localparam int SMW    = SAMPLE_WIDTH;
  localparam int CW     = COEFF_WIDTH;
  localparam int SW     = STATE_WIDTH;
  localparam int DATA_W = (COEFF_WIDTH > 32) ? 64 : 32;
  localparam int ADDR_W = (COEFF_WIDTH > 32) ? 6 : 5;
  // state fraction bits minus sample fraction bits
  localparam int SHIFT_D = (SW - Q_INT_BITS) - (SMW - 1);
  // headroom for node sums and doubled states
  localparam int XW = SW + 2;
  // output conversion width, room for the rounding add or the left shift
  localparam int EW = XW + 1 + ((SHIFT_D < 0) ? -SHIFT_D : 0);

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [XW-1:0] ext_st(input logic signed [SW-1:0] v);
    return {{(XW - SW){v[SW-1]}}, v};
  endfunction

  // saturate a widened node back to the state width
  function automatic logic signed [SW-1:0] sat_st(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v[XW-1:SW-1] == {(XW - SW + 1){v[XW-1]}}) begin
      r = v[SW-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      r = {1'b0, {(SW - 1){1'b1}}};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                 bypass;
  logic [CW-1:0]        coef_g;
  logic [CW-1:0]        coef_a1;
  logic [CW-1:0]        coef_a2;
  logic [CW-1:0]        mix_input;
  logic [CW-1:0]        mix_band;
  logic [CW-1:0]        mix_low;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  // registers sit at 4-byte steps, 8-byte steps with wide coefficients
  assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass    <= 1'b1;
      coef_g    <= '0;
      coef_a1   <= '0;
      coef_a2   <= '0;
      mix_input <= CW'(1) << (CW - Q_INT_BITS);
      mix_band  <= '0;
      mix_low   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BYPASS:    bypass    <= pwdata[0];
        REG_COEF_G:    coef_g    <= pwdata[CW-1:0];
        REG_COEF_A1:   coef_a1   <= pwdata[CW-1:0];
        REG_COEF_A2:   coef_a2   <= pwdata[CW-1:0];
        REG_MIX_INPUT: mix_input <= pwdata[CW-1:0];
        REG_MIX_BAND:  mix_band  <= pwdata[CW-1:0];
        REG_MIX_LOW:   mix_low   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BYPASS:    prdata = DATA_W'(bypass);
      REG_COEF_G:    prdata = DATA_W'(coef_g);
      REG_COEF_A1:   prdata = DATA_W'(coef_a1);
      REG_COEF_A2:   prdata = DATA_W'(coef_a2);
      REG_MIX_INPUT: prdata = DATA_W'(mix_input);
      REG_MIX_BAND:  prdata = DATA_W'(mix_band);
      REG_MIX_LOW:   prdata = DATA_W'(mix_low);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  svf_state_t             state;
  op_t                    op;
  logic                   issue;      // launch the current product next cycle
  logic signed [SW-1:0]   s1;         // first integrator
  logic signed [SW-1:0]   s2;         // second integrator
  logic signed [SW-1:0]   v0;         // input in state format
  logic signed [SW-1:0]   v3;         // input minus second state
  logic signed [SW-1:0]   v1;         // bandpass node
  logic signed [SW-1:0]   v2;         // lowpass node
  logic signed [SW-1:0]   t1;         // holds a1*s1 until a2*v3 arrives
  logic signed [XW-1:0]   yacc;       // output mix accumulator
  logic [SMW-1:0]         res;        // finished sample waiting for the output register

  logic                   in_accept;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // --------------------------------------------------------------------------
  // input conversion: sample to state format, then the first difference node
  // --------------------------------------------------------------------------
  logic signed [SW+SMW-1:0] x_ext;
  logic signed [SW+SMW-1:0] x_scaled;
  logic signed [SW-1:0]     v0_in;
  logic signed [SW-1:0]     v3_in;

  assign x_ext = {{SW{sample_in[SMW-1]}}, sample_in};

  generate
    if (SHIFT_D >= 0) begin : g_in_up
      assign x_scaled = x_ext <<< SHIFT_D;
    end else begin : g_in_down
      // fewer state fraction bits: floor
      assign x_scaled = x_ext >>> (-SHIFT_D);
    end
  endgenerate

  // the scaled sample always fits the state width
  assign v0_in = x_scaled[SW-1:0];
  assign v3_in = sat_st(ext_st(v0_in) - ext_st(s2));

  // --------------------------------------------------------------------------
  // shared serial multiplier and its operand select
  // --------------------------------------------------------------------------
  logic [CW-1:0]        mul_coef;
  logic [SW-1:0]        mul_node;
  logic                 mul_done;
  logic [SW-1:0]        mul_product;
  logic signed [SW-1:0] p;
  op_t                  op_next;

  always_comb begin
    case (op)
      OP_A1S1: begin mul_coef = coef_a1;   mul_node = s1; op_next = OP_A2V3; end
      OP_A2V3: begin mul_coef = coef_a2;   mul_node = v3; op_next = OP_GV1;  end
      OP_GV1:  begin mul_coef = coef_g;    mul_node = v1; op_next = OP_M0V0; end
      OP_M0V0: begin mul_coef = mix_input; mul_node = v0; op_next = OP_M1V1; end
      OP_M1V1: begin mul_coef = mix_band;  mul_node = v1; op_next = OP_M2V2; end
      OP_M2V2: begin mul_coef = mix_low;   mul_node = v2; op_next = OP_A1S1; end
      default: begin mul_coef = '0;        mul_node = '0; op_next = OP_A1S1; end
    endcase
  end

  svf_mul #(
    .COEF_W (CW),
    .NODE_W (SW)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (issue),
    .coef    (mul_coef),
    .node    (mul_node),
    .done    (mul_done),
    .product (mul_product)
  );

  assign p = mul_product;

  // --------------------------------------------------------------------------
  // output conversion: round half up to the sample step, saturate
  // --------------------------------------------------------------------------
  logic signed [EW-1:0] y_ext;
  logic signed [EW-1:0] y_scaled;
  logic [SMW-1:0]       y_sat;

  assign y_ext = {{(EW - XW){yacc[XW-1]}}, yacc};

  generate
    if (SHIFT_D > 0) begin : g_out_down
      localparam logic signed [EW-1:0] Y_HALF = EW'(1) << (SHIFT_D - 1);
      assign y_scaled = (y_ext + Y_HALF) >>> SHIFT_D;
    end else if (SHIFT_D == 0) begin : g_out_same
      assign y_scaled = y_ext;
    end else begin : g_out_up
      assign y_scaled = y_ext <<< (-SHIFT_D);
    end
  endgenerate

  always_comb begin
    if (y_scaled[EW-1:SMW-1] == {(EW - SMW + 1){y_scaled[EW-1]}}) begin
      y_sat = y_scaled[SMW-1:0];
    end else if (y_scaled[EW-1]) begin
      y_sat = {1'b1, {(SMW - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SMW - 1){1'b1}}};
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // idle -> mul (six products, each launched after the last one lands) -> conv -> done
  // bypass goes straight to done, clear stays in idle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_A1S1;
      issue     <= 1'b0;
      out_valid <= 1'b0;
      s1        <= '0;
      s2        <= '0;
    end else begin
      // in done the output register is reloaded by the done arm itself
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (operation == OPER_CLEAR) begin
              s1 <= '0;
              s2 <= '0;
            end else if (bypass) begin
              state <= ST_DONE;
            end else begin
              op    <= OP_A1S1;
              issue <= 1'b1;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (issue) begin
            issue <= 1'b0;
          end
          if (mul_done) begin
            // integrator updates once their nodes are final
            if (op == OP_GV1) begin
              s1 <= sat_st((ext_st(v1) <<< 1) - ext_st(s1));
            end
            if (op == OP_M0V0) begin
              s2 <= sat_st((ext_st(v2) <<< 1) - ext_st(s2));
            end
            op <= op_next;
            if (op == OP_M2V2) begin
              state <= ST_CONV;
            end else begin
              issue <= 1'b1;
            end
          end
        end
        ST_CONV: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hand over when the output register is free or being drained
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      v0  <= v0_in;
      v3  <= v3_in;
      res <= sample_in;
    end
    if (state == ST_MUL && mul_done) begin
      case (op)
        OP_A1S1: t1   <= p;
        OP_A2V3: v1   <= sat_st(ext_st(t1) + ext_st(p));
        OP_GV1:  v2   <= sat_st(ext_st(s2) + ext_st(p));
        OP_M0V0: yacc <= ext_st(p);
        OP_M1V1: yacc <= yacc + ext_st(p);
        OP_M2V2: yacc <= yacc + ext_st(p);
        default: ;
      endcase
    end
    if (state == ST_CONV) begin
      res <= y_sat;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      sample_out <= res;
    end
  end

endmodule

// ===== tb/sv/state_variable_filter_core_tb.sv =====
`timescale 1ns / 100ps

module state_variable_filter_core_tb
  import svf_pkg::*;
();

  // block configuration under test
  localparam int SW  = 24;
  localparam int CW  = 32;
  localparam int STW = 32;
  localparam int PAW = (CW > 32) ? 6 : 5;
  localparam int PDW = (CW > 32) ? 64 : 32;

  // fixed-point bookkeeping: samples Q1.(SW-1), coefficients and states Q8.x
  localparam int COEF_FRAC  = CW - Q_INT_BITS;
  localparam int STATE_FRAC = STW - Q_INT_BITS;
  localparam int SAMP_FRAC  = SW - 1;
  localparam int SHIFT_UP   = (STATE_FRAC > SAMP_FRAC) ? STATE_FRAC - SAMP_FRAC : 0;
  localparam int SHIFT_DN   = (STATE_FRAC < SAMP_FRAC) ? SAMP_FRAC - STATE_FRAC : 0;
  localparam longint OUT_HALF = (SHIFT_UP > 0) ? (longint'(1) <<< (SHIFT_UP - 1)) : 0;
  localparam real Q_ONE     = 2.0 ** COEF_FRAC;

  // timing budget: the settle pause is longer than a filter transaction from accept to sample_out valid
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_ITEMS   = 200;

  // extremes of the sample and coefficient fields
  localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] SMP_NEG1 = {SW{1'b1}};
  localparam logic [PDW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [PDW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [PDW-1:0] COEF_ONE = PDW'(1) << COEF_FRAC;

  // kinds of directed stimulus rows
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_REG
  } row_kind_t;

  // how a random phase picks its coefficients
  typedef enum logic [1:0] {
    TUNE_DESIGNED,
    TUNE_RANDOM,
    TUNE_EXTREME
  } tuning_t;

  typedef struct {
    row_kind_t              kind;
    logic                   op;
    logic [SW-1:0]          smp;
    logic [SW-1:0]          typed;
    logic [REG_IDX_W-1:0]   idx;
    logic [PDW-1:0]         value;
  } stim_row_t;

  // clock, reset and block ports; the inputs are known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OPER_FILTER;
  logic [SW-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SW-1:0] sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [PDW-1:0] pwdata = '0;
  logic [PDW-1:0] prdata;
  logic pready;

  // shadow of the filter: register copies and the two integrators
  logic   cfg_bypass;
  longint cfg_g, cfg_a1, cfg_a2, cfg_m0, cfg_m1, cfg_m2;
  longint integ1, integ2;

  // samples the block still owes us, oldest first
  logic [SW-1:0] expected_samples[$];
  logic [SW-1:0] want_sample;

  stim_row_t directed_rows[$];

  bit idling = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int filtered_count = 0;
  int bypassed_count = 0;
  int clear_count = 0;
  int reg_write_count = 0;
  int settings_count = 0;
  int samples_checked = 0;

  state_variable_filter_core #(
    .SAMPLE_WIDTH(SW),
    .COEFF_WIDTH (CW),
    .STATE_WIDTH (STW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic longint clip(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // coefficient times node, rounded to the state step with halves away from zero,
  // then clamped to the state range
  function automatic longint q_mul_round(input longint coef, input longint node);
    bit     neg;
    longint mag;
    longint lim;
    neg = (coef < 0) != (node < 0);
    mag = (coef < 0 ? -coef : coef) * (node < 0 ? -node : node);
    mag = (mag + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    lim = (longint'(1) <<< (STW - 1)) - 1 + (neg ? 1 : 0);
    if (mag > lim) mag = lim;
    return neg ? -mag : mag;
  endfunction

  function automatic void cfg_apply(input logic [REG_IDX_W-1:0] idx,
                                    input logic [PDW-1:0] value);
    longint c;
    c = longint'(signed'(value[CW-1:0]));
    case (idx)
      REG_BYPASS:    cfg_bypass = value[0];
      REG_COEF_G:    cfg_g = c;
      REG_COEF_A1:   cfg_a1 = c;
      REG_COEF_A2:   cfg_a2 = c;
      REG_MIX_INPUT: cfg_m0 = c;
      REG_MIX_BAND:  cfg_m1 = c;
      REG_MIX_LOW:   cfg_m2 = c;
      default: ;
    endcase
  endfunction

  // one step of the trapezoidal filter; returns 1 when the step yields a sample
  function automatic bit svf_predict(input logic op, input logic [SW-1:0] smp,
                                     output logic [SW-1:0] y_out);
    longint x, v0, v1, v2, v3, y;
    y_out = '0;
    if (op == OPER_CLEAR) begin
      integ1 = 0;
      integ2 = 0;
      clear_count++;
      return 1'b0;
    end
    if (cfg_bypass) begin
      y_out = smp;
      bypassed_count++;
      return 1'b1;
    end
    x  = longint'(signed'(smp));
    v0 = clip((x <<< SHIFT_UP) >>> SHIFT_DN, STW);
    v3 = clip(v0 - integ2, STW);
    v1 = clip(q_mul_round(cfg_a1, integ1) + q_mul_round(cfg_a2, v3), STW);
    v2 = clip(integ2 + q_mul_round(cfg_g, v1), STW);
    integ1 = clip(2 * v1 - integ1, STW);
    integ2 = clip(2 * v2 - integ2, STW);
    y = q_mul_round(cfg_m0, v0) + q_mul_round(cfg_m1, v1) + q_mul_round(cfg_m2, v2);
    y = ((y + OUT_HALF) >>> SHIFT_UP) <<< SHIFT_DN;
    y_out = SW'(clip(y, SW));
    filtered_count++;
    return 1'b1;
  endfunction

  // present one transaction, hold it until accepted, then maybe leave a gap
  task automatic send_item(input logic op, input logic [SW-1:0] smp, input bit use_typed,
                           input logic [SW-1:0] typed);
    logic [SW-1:0] y;
    in_valid  <= 1'b1;
    operation <= op;
    sample_in <= smp;
    do @(posedge clk); while (in_stall);
    if (svf_predict(op, smp, y))
      expected_samples.push_back(use_typed ? typed : y);
    if (idling && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // block goes quiet: nothing owed, then a settling pause
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write a register, then read it straight back
  task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input logic [PDW-1:0] value);
    logic [PDW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAW'(idx) << (PAW - REG_IDX_W);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_apply(idx, value);
    reg_write_count++;
    // read setup, psel stays up
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == REG_BYPASS) ? PDW'(value[0]) : value;
    if (prdata !== want)
      report_mismatch($sformatf("readback of register %0d", idx), 64'(prdata), 64'(want));
    psel    <= 1'b0;
    penable <= 1'b0;
    // bus idles before the next access
    @(posedge clk);
  endtask

  function automatic void add_row(input row_kind_t kind, input logic op,
                                  input logic [SW-1:0] smp, input logic [SW-1:0] typed);
    stim_row_t r;
    r = '{kind: kind, op: op, smp: smp, typed: typed, idx: '0, value: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDW-1:0] value);
    stim_row_t r;
    r = '{kind: ROW_REG, op: OPER_FILTER, smp: '0, typed: '0, idx: idx, value: value};
    directed_rows.push_back(r);
  endfunction

  // same value into all six coefficient and mix registers
  function automatic void add_all_coefs(input logic [PDW-1:0] value);
    add_reg(REG_COEF_G, value);
    add_reg(REG_COEF_A1, value);
    add_reg(REG_COEF_A2, value);
    add_reg(REG_MIX_INPUT, value);
    add_reg(REG_MIX_BAND, value);
    add_reg(REG_MIX_LOW, value);
  endfunction

  function automatic logic [PDW-1:0] to_q(input real r);
    return PDW'($rtoi(r * Q_ONE));
  endfunction

  function automatic real rnd_real(input real span);
    return span * (real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0);
  endfunction

  function automatic logic [PDW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      default: return COEF_ONE;
    endcase
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return SMP_MAX;
          1: return SMP_MIN;
          2: return '0;
          default: return SMP_NEG1;
        endcase
      end
      1, 2: return SW'(int'($urandom_range(0, 131072)) - 65536);
      default: return SW'($urandom);
    endcase
  endfunction

  // load one full register setting for a random phase
  task automatic program_setting(input tuning_t tuning, input logic byp);
    real g, k, a1, m0, m1, m2;
    logic [PDW-1:0] vals[6];
    case (tuning)
      TUNE_DESIGNED: begin
        // a stable filter from random g and damping k: a1 = 1/(1 + g*(g + k)), a2 = g*a1
        g  = 0.005 + 1.5 * real'($urandom_range(0, 1000)) / 1000.0;
        k  = 0.05 + 2.0 * real'($urandom_range(0, 1000)) / 1000.0;
        a1 = 1.0 / (1.0 + g * (g + k));
        m0 = rnd_real(2.0);
        m1 = rnd_real(2.0);
        m2 = rnd_real(2.0);
        vals = '{to_q(g), to_q(a1), to_q(g * a1), to_q(m0), to_q(m1), to_q(m2)};
      end
      TUNE_RANDOM:
        foreach (vals[i]) vals[i] = PDW'($urandom);
      default:
        foreach (vals[i]) vals[i] = pick_extreme();
    endcase
    reg_access(REG_BYPASS, PDW'(byp));
    reg_access(REG_COEF_G, vals[0]);
    reg_access(REG_COEF_A1, vals[1]);
    reg_access(REG_COEF_A2, vals[2]);
    reg_access(REG_MIX_INPUT, vals[3]);
    reg_access(REG_MIX_BAND, vals[4]);
    reg_access(REG_MIX_LOW, vals[5]);
    settings_count++;
  endtask

  // output side: random stall bursts, none once idling is off
  always @(posedge clk) begin
    if (rst || !idling) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: every accepted sample against the oldest one owed
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample_out with nothing owed", 64'(sample_out), 64'(0));
      end else begin
        want_sample = expected_samples.pop_front();
        samples_checked++;
        if (sample_out !== want_sample)
          report_mismatch("sample_out", 64'(sample_out), 64'(want_sample));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d samples still owed", cycle_count,
               expected_samples.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bit after_item;
    int waited;
    tuning_t tuning;

    // shadow starts from the reset values
    cfg_bypass = 1'b1;
    cfg_g  = 0;
    cfg_a1 = 0;
    cfg_a2 = 0;
    cfg_m0 = longint'(1) <<< COEF_FRAC;
    cfg_m1 = 0;
    cfg_m2 = 0;
    integ1 = 0;
    integ2 = 0;

    // straight after reset the block is in bypass: output equals input
    add_row(ROW_CHECKED, OPER_FILTER, '0, '0);
    add_row(ROW_CHECKED, OPER_FILTER, SMP_MAX, SMP_MAX);
    add_row(ROW_CHECKED, OPER_FILTER, SMP_MIN, SMP_MIN);
    add_row(ROW_CHECKED, OPER_FILTER, SMP_NEG1, SMP_NEG1);
    // clear while bypassed gives nothing back
    add_row(ROW_ITEM, OPER_CLEAR, SMP_MAX, '0);
    add_row(ROW_CHECKED, OPER_FILTER, {(SW/2){2'b01}}, {(SW/2){2'b01}});
    add_row(ROW_CHECKED, OPER_FILTER, {(SW/2){2'b10}}, {(SW/2){2'b10}});
    // filtering with reset coefficients is unity gain on the dry path
    add_reg(REG_BYPASS, '0);
    add_row(ROW_CHECKED, OPER_FILTER, SMP_MAX, SMP_MAX);
    add_row(ROW_CHECKED, OPER_FILTER, SMP_MIN, SMP_MIN);
    add_row(ROW_CHECKED, OPER_FILTER, SW'(1), SW'(1));
    add_row(ROW_CHECKED, OPER_FILTER, SMP_NEG1, SMP_NEG1);
    // largest positive coefficients everywhere: states and output driven to the rails
    add_all_coefs(COEF_MAX);
    add_row(ROW_ITEM, OPER_FILTER, SMP_MAX, '0);
    add_row(ROW_ITEM, OPER_FILTER, SMP_MIN, '0);
    add_row(ROW_ITEM, OPER_CLEAR, '0, '0);
    add_row(ROW_ITEM, OPER_FILTER, SMP_MAX, '0);
    // most negative coefficients everywhere
    add_all_coefs(COEF_MIN);
    add_row(ROW_ITEM, OPER_FILTER, SMP_MIN, '0);
    add_row(ROW_ITEM, OPER_FILTER, SMP_MAX, '0);
    add_row(ROW_ITEM, OPER_FILTER, SW'(1), '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table; register rows only once the block has gone quiet
    after_item = 1'b0;
    settings_count = 1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (after_item) begin
          wait_quiet();
          settings_count++;
        end
        reg_access(directed_rows[i].idx, directed_rows[i].value);
        after_item = 1'b0;
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].smp,
                  directed_rows[i].kind == ROW_CHECKED, directed_rows[i].typed);
        after_item = 1'b1;
      end
    end

    // random phases: mostly designed filters, one fully random, one at the extremes,
    // one bypassed; the last runs with no idling on either side
    for (int phase = 0; phase < 6; phase++) begin
      wait_quiet();
      case (phase)
        1: tuning = TUNE_RANDOM;
        4: tuning = TUNE_EXTREME;
        default: tuning = TUNE_DESIGNED;
      endcase
      program_setting(tuning, phase == 2);
      idling = (phase != 5);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item(($urandom_range(0, 24) == 0) ? OPER_CLEAR : OPER_FILTER, rand_sample(),
                  1'b0, '0);
    end

    // drain with a bound, then a settling pause for anything stray
    in_valid <= 1'b0;
    waited = 0;
    while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    foreach (expected_samples[i])
      report_mismatch("sample never delivered", 64'(0), 64'(expected_samples[i]));

    $display("checked %0d samples: %0d filtered, %0d bypassed, plus %0d clears",
             samples_checked, filtered_count, bypassed_count, clear_count);
    $display("%0d register writes read back across %0d settings, %0d mismatches",
             reg_write_count, settings_count, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
